// ===== rtl/cwss_pkg.sv =====
package cwss_pkg;

  typedef enum logic [1:0] {
    OP_SET_IN_SIZE  = 2'd0,
    OP_SET_OUT_SIZE = 2'd1,
    OP_SET_PAN      = 2'd2
  } cmd_op_e;

  typedef enum logic [3:0] {
    REG_IN_WIDTH   = 4'd0,
    REG_IN_HEIGHT  = 4'd1,
    REG_OUT_WIDTH  = 4'd2,
    REG_OUT_HEIGHT = 4'd3,
    REG_PROC_CTRL  = 4'd4,
    REG_FIRST_COL  = 4'd5,
    REG_LAST_COL   = 4'd6,
    REG_FIRST_ROW  = 4'd7,
    REG_LAST_ROW   = 4'd8
  } reg_sel_e;

  typedef enum logic [1:0] {
    JOB_DONE     = 2'd0,
    JOB_IN_SIZE  = 2'd1,
    JOB_OUT_SIZE = 2'd2,
    JOB_PAN      = 2'd3
  } job_kind_e;

  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic              [1:0]  opcode;
    logic signed       [11:0] x_value;
    logic signed       [11:0] y_value;
  } cmd_t;

  typedef struct packed {
    logic       write_valid;
    logic [3:0] reg_select;
    logic [9:0] write_value;
    logic       last;
  } rsp_t;

  // one classified command: the values of its run, in emission order
  typedef struct packed {
    job_kind_e       kind;
    logic [3:0][9:0] val;
  } job_t;

endpackage

// ===== rtl/cwss_front.sv =====
module cwss_front #(
  parameter int unsigned MAX_WIDTH  = 352,
  parameter int unsigned MIN_WIDTH  = 8,
  parameter int unsigned MAX_HEIGHT = 288,
  parameter int unsigned MIN_HEIGHT = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  cwss_pkg::cmd_t  in_data_i,
  input  logic            full_i,
  output logic            push_o,
  output cwss_pkg::job_t  job_o
);

  localparam logic [9:0] MaxW = 10'(MAX_WIDTH);
  localparam logic [9:0] MinW = 10'(MIN_WIDTH);
  localparam logic [9:0] MaxH = 10'(MAX_HEIGHT);
  localparam logic [9:0] MinH = 10'(MIN_HEIGHT);

  function automatic logic [9:0] clamp_size(input logic signed [11:0] v,
                                            input logic [9:0] lo,
                                            input logic [9:0] hi);
    logic signed [12:0] s;
    logic signed [12:0] l;
    logic signed [12:0] h;
    s = 13'(v);
    l = $signed({3'b000, lo});
    h = $signed({3'b000, hi});
    if (s > h) s = h;
    // minimum wins when the limits cross
    if (s < l) s = l;
    return s[9:0];
  endfunction

  function automatic logic signed [12:0] clamp_pan(input logic signed [11:0] v,
                                                   input logic [8:0] lim);
    logic signed [12:0] s;
    logic signed [12:0] h;
    s = 13'(v);
    h = $signed({4'b0000, lim});
    if (s < -h) s = -h;
    else if (s > h) s = h;
    return s;
  endfunction

  function automatic logic [8:0] half_spare(input logic [9:0] maxv, input logic [9:0] size);
    logic signed [11:0] d;
    d = $signed({2'b00, maxv}) - $signed({2'b00, size});
    if (d < 0) d = '0;
    return d[9:1];
  endfunction

  function automatic logic [9:0] half_sum(input logic [9:0] maxv, input logic [9:0] size);
    logic [10:0] s;
    s = {1'b0, maxv} + {1'b0, size};
    return s[10:1];
  endfunction

  logic [9:0] in_w_q, in_w_d, in_h_q, in_h_d;
  logic [9:0] out_w_q, out_w_d, out_h_q, out_h_d;
  // pan limits and window centre terms, kept ready for the next pan
  logic [8:0] dx_q, dx_d, dy_q, dy_d;
  logic [9:0] hx_q, hx_d, hy_q, hy_d;

  logic signed [11:0] x_al, y_al;
  logic [9:0]         sx, sy;
  logic signed [12:0] px, py;
  logic signed [12:0] fc, lc, fr, lr;
  logic               upd_in, upd_out;

  assign in_ready_o = ~full_i;
  assign push_o     = in_valid_i & ~full_i;

  assign x_al = {in_data_i.x_value[11:2], 2'b00};
  assign y_al = {in_data_i.y_value[11:2], 2'b00};
  assign sx   = clamp_size(x_al, MinW, MaxW);
  assign sy   = clamp_size(y_al, MinH, MaxH);
  assign px   = clamp_pan(x_al, dx_q);
  assign py   = clamp_pan(y_al, dy_q);

  assign fc = px + $signed({4'b0000, dx_q}) + 13'sd4;
  assign lc = px + $signed({3'b000, hx_q}) + 13'sd8;
  assign fr = py + $signed({4'b0000, dy_q}) + 13'sd4;
  assign lr = py + $signed({3'b000, hy_q}) + 13'sd8;

  always_comb begin
    job_o.kind = cwss_pkg::JOB_DONE;
    job_o.val  = '0;
    upd_in     = 1'b0;
    upd_out    = 1'b0;
    unique case (in_data_i.opcode)
      cwss_pkg::OP_SET_IN_SIZE: begin
        if (sx != in_w_q || sy != in_h_q) begin
          upd_in        = 1'b1;
          job_o.kind    = cwss_pkg::JOB_IN_SIZE;
          job_o.val[0]  = sx;
          job_o.val[1]  = sy;
        end
      end
      cwss_pkg::OP_SET_OUT_SIZE: begin
        if (sx != out_w_q || sy != out_h_q) begin
          upd_out       = 1'b1;
          job_o.kind    = cwss_pkg::JOB_OUT_SIZE;
          job_o.val[0]  = sx;
          job_o.val[1]  = sy;
        end
      end
      cwss_pkg::OP_SET_PAN: begin
        if (px != 0 || py != 0) begin
          job_o.kind    = cwss_pkg::JOB_PAN;
          job_o.val[0]  = {2'b00, fc[9:2]};
          job_o.val[1]  = {2'b00, lc[9:2]};
          job_o.val[2]  = {2'b00, fr[9:2]};
          job_o.val[3]  = {2'b00, lr[9:2]};
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    in_w_d  = in_w_q;
    in_h_d  = in_h_q;
    out_w_d = out_w_q;
    out_h_d = out_h_q;
    dx_d    = dx_q;
    dy_d    = dy_q;
    hx_d    = hx_q;
    hy_d    = hy_q;
    if (push_o && upd_in) begin
      in_w_d = sx;
      in_h_d = sy;
      dx_d   = half_spare(MaxW, sx);
      dy_d   = half_spare(MaxH, sy);
      hx_d   = half_sum(MaxW, sx);
      hy_d   = half_sum(MaxH, sy);
    end
    if (push_o && upd_out) begin
      out_w_d = sx;
      out_h_d = sy;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_w_q  <= '0;
      in_h_q  <= '0;
      out_w_q <= '0;
      out_h_q <= '0;
      dx_q    <= 9'(MAX_WIDTH / 2);
      dy_q    <= 9'(MAX_HEIGHT / 2);
      hx_q    <= 10'(MAX_WIDTH / 2);
      hy_q    <= 10'(MAX_HEIGHT / 2);
    end else begin
      in_w_q  <= in_w_d;
      in_h_q  <= in_h_d;
      out_w_q <= out_w_d;
      out_h_q <= out_h_d;
      dx_q    <= dx_d;
      dy_q    <= dy_d;
      hx_q    <= hx_d;
      hy_q    <= hy_d;
    end
  end

endmodule

// ===== rtl/cwss_queue.sv =====
module cwss_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cwss_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output cwss_pkg::job_t job_o
);

  localparam int unsigned Depth = cwss_pkg::QueueDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  cwss_pkg::job_t      mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    else if (!push_i && pop_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= job_i;
  end

endmodule

// ===== rtl/cwss_back.sv =====
module cwss_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  input  cwss_pkg::job_t job_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output cwss_pkg::rsp_t out_data_o
);

  function automatic logic [1:0] last_idx(input cwss_pkg::job_kind_e kind);
    logic [1:0] n;
    unique case (kind)
      cwss_pkg::JOB_DONE:     n = 2'd0;
      cwss_pkg::JOB_IN_SIZE:  n = 2'd1;
      cwss_pkg::JOB_OUT_SIZE: n = 2'd2;
      cwss_pkg::JOB_PAN:      n = 2'd3;
      default:                n = 2'd0;
    endcase
    return n;
  endfunction

  // done-only results carry select zero as well
  function automatic logic [3:0] base_sel(input cwss_pkg::job_kind_e kind);
    logic [3:0] s;
    unique case (kind)
      cwss_pkg::JOB_DONE:     s = 4'(cwss_pkg::REG_IN_WIDTH);
      cwss_pkg::JOB_IN_SIZE:  s = 4'(cwss_pkg::REG_IN_WIDTH);
      cwss_pkg::JOB_OUT_SIZE: s = 4'(cwss_pkg::REG_OUT_WIDTH);
      cwss_pkg::JOB_PAN:      s = 4'(cwss_pkg::REG_FIRST_COL);
      default:                s = 4'(cwss_pkg::REG_IN_WIDTH);
    endcase
    return s;
  endfunction

  logic [1:0]      idx_q, idx_d;
  logic            out_valid_q, out_valid_d;
  cwss_pkg::rsp_t  out_q, out_d;
  logic            fire, is_last;

  assign fire    = job_valid_i & (~out_valid_q | out_ready_i);
  assign is_last = (idx_q == last_idx(job_i.kind));
  assign pop_o   = fire & is_last;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (fire) begin
      out_valid_d       = 1'b1;
      out_d.write_valid = (job_i.kind != cwss_pkg::JOB_DONE);
      out_d.reg_select  = base_sel(job_i.kind) + {2'b00, idx_q};
      out_d.write_value = job_i.val[idx_q];
      out_d.last        = is_last;
      idx_d             = is_last ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/camera_window_setup_sequencer_core.sv =====
// path: a request enters the queue, and its first result is then registered at
// the output; throughput: one result per cycle from the back end unless the
// output stalls, 1 to 4 results a request (done 1, input size 2, output size 3,
// pan 4); the front takes one a cycle into a two-entry queue while room remains
// reset: asynchronous active low, clears stored sizes, queue and output valid
module camera_window_setup_sequencer_core #(
  parameter int unsigned MAX_WIDTH  = 352,
  parameter int unsigned MIN_WIDTH  = 8,
  parameter int unsigned MAX_HEIGHT = 288,
  parameter int unsigned MIN_HEIGHT = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  cwss_pkg::cmd_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output cwss_pkg::rsp_t out_data_o
);

  logic           push, full, pop, job_valid;
  cwss_pkg::job_t job_in, job_out;

  cwss_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MIN_WIDTH (MIN_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MIN_HEIGHT(MIN_HEIGHT)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i (in_data_i),
    .full_i    (full),
    .push_o    (push),
    .job_o     (job_in)
  );

  cwss_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job_in),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(job_valid),
    .job_o  (job_out)
  );

  cwss_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(job_valid),
    .job_i      (job_out),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

// ===== rtl/cwss_checker.sv =====
module cwss_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input cwss_pkg::rsp_t out_data_o
);

  logic out_acc;
  assign out_acc = out_valid_o & out_ready_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  a_done_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.write_valid |->
      out_data_o.last && out_data_o.reg_select == 4'(cwss_pkg::REG_IN_WIDTH) &&
      out_data_o.write_value == 10'd0)
    else $error("malformed done-only result");

  a_proc_ctrl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.write_valid &&
      out_data_o.reg_select == 4'(cwss_pkg::REG_PROC_CTRL) |->
      out_data_o.last && out_data_o.write_value == 10'd0)
    else $error("sizer bypass clear not last or not zero");

  // a run continues the very next cycle with the following register
  a_run_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !out_data_o.last |=>
      out_valid_o && out_data_o.write_valid &&
      out_data_o.reg_select == $past(out_data_o.reg_select) + 4'd1)
    else $error("run broken or out of order");

endmodule

bind camera_window_setup_sequencer_core cwss_checker u_cwss_checker (.*);
